[design/ssca_pkg.sv]
// Shared types, widths and codes of the slab size class allocator.
package ssca_pkg;

	localparam int BLOCK_BYTES_DEF = 65536;
	localparam int POOL_BLOCKS_DEF = 4;
	localparam int MAX_CLASSES_DEF = 32;
	localparam int ALIGN_BYTES_DEF = 8;

	localparam int ADDR_W  = 18;
	localparam int SIZE_W  = 17;
	localparam int CNT_W   = 14;
	localparam int FIRST_W = 13;
	localparam int CLS_W   = 5;
	localparam int STAT_W  = 3;
	localparam int NCLS_W  = 6;
	localparam int PROD_W  = SIZE_W + CNT_W;
	localparam int CARVE_W = 34;
	localparam int DCNT_W  = $clog2(SIZE_W);
	localparam int HEAD_W  = ADDR_W + 1;

	localparam logic [FIRST_W-1:0] FIRST_RST = FIRST_W'(72);
	localparam logic [SIZE_W-1:0]  LIMIT_RST = SIZE_W'(16384);

	typedef enum logic [1:0] {
		OP_INIT  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_TOO_BIG  = 3'd1;
	localparam logic [STAT_W-1:0] ST_NO_MEM   = 3'd2;
	localparam logic [STAT_W-1:0] ST_BAD_CLS  = 3'd3;
	localparam logic [STAT_W-1:0] ST_NO_INIT  = 3'd4;

	localparam logic CFG_FIRST = 1'b0;
	localparam logic CFG_LIMIT = 1'b1;

	typedef struct packed {
		logic [1:0]        op;
		logic [SIZE_W-1:0] req_bytes;
		logic [ADDR_W-1:0] free_addr;
		logic [CLS_W-1:0]  free_class;
	} in_item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ADDR_W-1:0] chunk_addr;
		logic [CLS_W-1:0]  chunk_class;
		logic [SIZE_W-1:0] chunk_bytes;
		logic [NCLS_W-1:0] class_count;
	} out_item_t;

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [CNT_W-1:0]  count;
		logic              head_valid;
		logic [ADDR_W-1:0] head_addr;
		logic [ADDR_W-1:0] base;
		logic [CNT_W-1:0]  left;
	} class_entry_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_INIT_CHK,
		S_DIV,
		S_MUL,
		S_CARVE,
		S_CLR,
		S_SEARCH,
		S_PAGE_CARVE,
		S_TAKE_MUL,
		S_TAKE,
		S_POP_SLOT,
		S_POP_RD,
		S_FREE_SLOT,
		S_FREE_WR,
		S_DONE
	} state_t;

endpackage

[design/slab_size_class_allocator.sv]
// Slab allocator with geometric size classes over a pool of fixed blocks.
//
//  channel   signals                          direction
//  in        in_valid, in_stall, in_item      item in (op, request, free)
//  out       out_valid, out_stall, out_item   one result per item of op 0..2
//  cfg       cfg_we, cfg_index, cfg_data      register writes, no read-back
//
// Allocate walks the classes, then pops a free list or takes from a live page,
// with a carve step first when a page is carved; free reads then writes. Each
// fold of a link slot into the store adds a step. Init runs a 17-step divider
// per class and clears each unused class entry. Both memory reads are registered.
// No clearing pass after reset: the class table is rewritten by every init.
// A new item is taken while a result still waits behind out_stall.
module slab_size_class_allocator
	import ssca_pkg::*;
#(
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
	parameter int POOL_BLOCKS = POOL_BLOCKS_DEF,
	parameter int MAX_CLASSES = MAX_CLASSES_DEF,
	parameter int ALIGN_BYTES = ALIGN_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_item_t          in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output out_item_t         out_item,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [SIZE_W-1:0] cfg_data
);

	localparam int    ASH        = $clog2(ALIGN_BYTES);
	localparam longint POOL      = longint'(BLOCK_BYTES) * longint'(POOL_BLOCKS);
	localparam longint LINK_DEPTH = POOL / ALIGN_BYTES;
	localparam int    LAW        = $clog2(LINK_DEPTH);
	localparam int    SLW        = ADDR_W - ASH;
	localparam int    SW         = (SLW > LAW) ? SLW : LAW;
	localparam int    CW         = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam int    CNW        = $clog2(MAX_CLASSES + 1);
	localparam int    CUR_W      = $clog2(POOL + 1);
	localparam int    BL_W       = $clog2(BLOCK_BYTES + 1);

	state_t              state_q, state_d;
	logic [FIRST_W-1:0]  first_q;
	logic [SIZE_W-1:0]   limit_q;
	logic [CNW-1:0]      num_q, num_d, n_q, n_d;
	logic [CUR_W-1:0]    cursor_q, cursor_d;
	logic [BL_W-1:0]     bleft_q, bleft_d;
	logic                ovalid_q, ovalid_d;
	out_item_t           out_q, out_d;

	in_item_t            item_q, item_d;
	logic [CW-1:0]       cls_q, cls_d;
	logic [SIZE_W-1:0]   size_q, size_d;
	logic [SIZE_W:0]     rem_q, rem_d;
	logic [SIZE_W-1:0]   quo_q, quo_d;
	logic [DCNT_W-1:0]   dcnt_q, dcnt_d;
	logic [PROD_W-1:0]   prod_q, prod_d;
	class_entry_t        ent_q, ent_d;
	logic [SW-1:0]       slot_q, slot_d;
	logic [STAT_W-1:0]   stat_q, stat_d;
	logic [ADDR_W-1:0]   addr_q, addr_d;
	logic                has_cls_q, has_cls_d;

	logic                cram_we;
	logic [CW-1:0]       cram_waddr;
	class_entry_t        cram_wdata, cram_rdata;
	logic                lram_we;
	logic [HEAD_W-1:0]   lram_wdata, lram_rdata;

	logic [CARVE_W-1:0]  need, nxt, cbase, cur_new, bl_new, bl_w, cur_w;
	logic                fits, c_ok;
	logic [SIZE_W:0]     dtry;
	logic [SIZE_W-1:0]   size_al, size0;
	logic                slot_big;
	logic [CNW-1:0]      cls_next;

	ssca_ram #(
		.WIDTH($bits(class_entry_t)),
		.DEPTH(MAX_CLASSES)
	) u_class_ram (
		.clk   (clk),
		.we    (cram_we),
		.waddr (cram_waddr),
		.wdata (cram_wdata),
		.raddr (cls_d),
		.rdata (cram_rdata)
	);

	ssca_ram #(
		.WIDTH(HEAD_W),
		.DEPTH(int'(LINK_DEPTH))
	) u_link_ram (
		.clk   (clk),
		.we    (lram_we),
		.waddr (slot_q[LAW-1:0]),
		.wdata (lram_wdata),
		.raddr (slot_q[LAW-1:0]),
		.rdata (lram_rdata)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = ovalid_q;
	assign out_item  = out_q;

	// Page carving: bump within the block, else move to the next block.
	always_comb begin
		need    = (CARVE_W'(prod_q) + CARVE_W'(ALIGN_BYTES - 1))
			& ~CARVE_W'(ALIGN_BYTES - 1);
		bl_w    = CARVE_W'(bleft_q);
		cur_w   = CARVE_W'(cursor_q);
		fits    = need < bl_w;
		nxt     = cur_w + bl_w;
		c_ok    = fits || !((need > CARVE_W'(BLOCK_BYTES))
			|| (nxt + need > CARVE_W'(POOL)));
		cbase   = fits ? cur_w : nxt;
		cur_new = cbase + need;
		bl_new  = fits ? (bl_w - need) : (CARVE_W'(BLOCK_BYTES) - need);
	end

	assign dtry     = {rem_q[SIZE_W-1:0], quo_q[SIZE_W-1]};
	assign size_al  = (size_q + SIZE_W'(ALIGN_BYTES - 1)) & ~SIZE_W'(ALIGN_BYTES - 1);
	assign size0    = (first_q == '0) ? SIZE_W'(ALIGN_BYTES) : SIZE_W'(first_q);
	assign slot_big = 64'(slot_q) >= 64'(LINK_DEPTH);
	assign cls_next = CNW'(cls_q) + CNW'(1);

	always_comb begin
		state_d    = state_q;
		num_d      = num_q;
		n_d        = n_q;
		cursor_d   = cursor_q;
		bleft_d    = bleft_q;
		ovalid_d   = ovalid_q;
		out_d      = out_q;
		item_d     = item_q;
		cls_d      = cls_q;
		size_d     = size_q;
		rem_d      = rem_q;
		quo_d      = quo_q;
		dcnt_d     = dcnt_q;
		prod_d     = prod_q;
		ent_d      = ent_q;
		slot_d     = slot_q;
		stat_d     = stat_q;
		addr_d     = addr_q;
		has_cls_d  = has_cls_q;
		cram_we    = 1'b0;
		cram_waddr = cls_q;
		cram_wdata = ent_q;
		lram_we    = 1'b0;
		lram_wdata = {cram_rdata.head_valid, cram_rdata.head_addr};

		if (ovalid_q && !out_stall) begin
			ovalid_d = 1'b0;
		end

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					item_d    = in_item;
					stat_d    = ST_OK;
					addr_d    = '0;
					has_cls_d = 1'b0;
					cls_d     = '0;
					slot_d    = SW'(in_item.free_addr[ADDR_W-1:ASH]);
					if (in_item.op == OP_INIT) begin
						size_d   = size0;
						cursor_d = '0;
						bleft_d  = BL_W'(BLOCK_BYTES);
						n_d      = '0;
						num_d    = '0;
						state_d  = S_INIT_CHK;
					end else if (in_item.op == OP_NONE) begin
						state_d = S_IDLE;
					end else if (num_q == '0) begin
						stat_d  = ST_NO_INIT;
						state_d = S_DONE;
					end else if (in_item.op == OP_ALLOC) begin
						state_d = S_SEARCH;
					end else if (CNW'(in_item.free_class) >= num_q) begin
						stat_d  = ST_BAD_CLS;
						state_d = S_DONE;
					end else begin
						cls_d   = in_item.free_class[CW-1:0];
						state_d = S_FREE_SLOT;
					end
				end
			end
			S_INIT_CHK: begin
				if ((n_q < CNW'(MAX_CLASSES))
					&& ((20'(size_q) << 2) + 20'(size_q) < (20'(limit_q) << 2))) begin
					size_d  = size_al;
					rem_d   = '0;
					quo_d   = limit_q;
					dcnt_d  = '0;
					cls_d   = n_q[CW-1:0];
					state_d = S_DIV;
				end else begin
					num_d = n_q;
					if (n_q < CNW'(MAX_CLASSES)) begin
						cls_d   = n_q[CW-1:0];
						state_d = S_CLR;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_DIV: begin
				// Restoring divide, one quotient bit a cycle.
				if (dtry >= {1'b0, size_q}) begin
					rem_d = dtry - {1'b0, size_q};
					quo_d = {quo_q[SIZE_W-2:0], 1'b1};
				end else begin
					rem_d = dtry;
					quo_d = {quo_q[SIZE_W-2:0], 1'b0};
				end
				dcnt_d = dcnt_q + DCNT_W'(1);
				if (dcnt_q == DCNT_W'(SIZE_W - 1)) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				ent_d       = '0;
				ent_d.size  = size_q;
				ent_d.count = quo_q[CNT_W-1:0];
				prod_d      = PROD_W'(size_q) * PROD_W'(quo_q[CNT_W-1:0]);
				state_d     = S_CARVE;
			end
			S_CARVE: begin
				cram_wdata = ent_q;
				if (ent_q.count != '0) begin
					if (c_ok) begin
						cram_wdata.base = ADDR_W'(cbase);
						cram_wdata.left = ent_q.count;
						cursor_d        = CUR_W'(cur_new);
						bleft_d         = BL_W'(bl_new);
					end else begin
						stat_d = ST_NO_MEM;
					end
				end
				cram_we = 1'b1;
				size_d  = size_q + (size_q >> 2);
				n_d     = n_q + CNW'(1);
				state_d = S_INIT_CHK;
			end
			S_CLR: begin
				cram_we    = 1'b1;
				cram_wdata = '0;
				if (cls_q == CW'(MAX_CLASSES - 1)) begin
					state_d = S_DONE;
				end else begin
					cls_d = cls_q + CW'(1);
				end
			end
			S_SEARCH: begin
				if (item_q.req_bytes > cram_rdata.size) begin
					if (cls_next >= num_q) begin
						stat_d  = ST_TOO_BIG;
						state_d = S_DONE;
					end else begin
						cls_d = cls_q + CW'(1);
					end
				end else begin
					ent_d     = cram_rdata;
					has_cls_d = 1'b1;
					if (cram_rdata.head_valid) begin
						addr_d  = cram_rdata.head_addr;
						slot_d  = SW'(cram_rdata.head_addr[ADDR_W-1:ASH]);
						state_d = S_POP_SLOT;
					end else if (cram_rdata.left != '0) begin
						state_d = S_TAKE_MUL;
					end else if (cram_rdata.count == '0) begin
						stat_d  = ST_NO_MEM;
						state_d = S_DONE;
					end else begin
						prod_d  = PROD_W'(cram_rdata.size) * PROD_W'(cram_rdata.count);
						state_d = S_PAGE_CARVE;
					end
				end
			end
			S_PAGE_CARVE: begin
				if (c_ok) begin
					ent_d.base = ADDR_W'(cbase);
					ent_d.left = ent_q.count;
					cursor_d   = CUR_W'(cur_new);
					bleft_d    = BL_W'(bl_new);
					state_d    = S_TAKE_MUL;
				end else begin
					stat_d  = ST_NO_MEM;
					state_d = S_DONE;
				end
			end
			S_TAKE_MUL: begin
				// Hand out the page from the highest chunk down.
				ent_d.left = ent_q.left - CNT_W'(1);
				prod_d     = PROD_W'(ent_q.left - CNT_W'(1)) * PROD_W'(ent_q.size);
				state_d    = S_TAKE;
			end
			S_TAKE: begin
				addr_d  = ent_q.base + prod_q[ADDR_W-1:0];
				cram_we = 1'b1;
				state_d = S_DONE;
			end
			S_POP_SLOT: begin
				if (slot_big) begin
					slot_d = slot_q - SW'(LINK_DEPTH);
				end else begin
					state_d = S_POP_RD;
				end
			end
			S_POP_RD: begin
				cram_wdata            = ent_q;
				cram_wdata.head_valid = lram_rdata[HEAD_W-1];
				cram_wdata.head_addr  = lram_rdata[ADDR_W-1:0];
				cram_we               = 1'b1;
				state_d               = S_DONE;
			end
			S_FREE_SLOT: begin
				if (slot_big) begin
					slot_d = slot_q - SW'(LINK_DEPTH);
				end else begin
					state_d = S_FREE_WR;
				end
			end
			S_FREE_WR: begin
				// Push: link the old head behind the freed chunk.
				lram_we               = 1'b1;
				cram_wdata            = cram_rdata;
				cram_wdata.head_valid = 1'b1;
				cram_wdata.head_addr  = item_q.free_addr;
				cram_we               = 1'b1;
				state_d               = S_DONE;
			end
			S_DONE: begin
				if (!ovalid_q || !out_stall) begin
					ovalid_d          = 1'b1;
					out_d.status      = stat_q;
					out_d.chunk_addr  = (stat_q == ST_OK) ? addr_q : '0;
					out_d.chunk_class = has_cls_q ? CLS_W'(cls_q) : '0;
					out_d.chunk_bytes = has_cls_q ? ent_q.size : '0;
					out_d.class_count = NCLS_W'(num_q);
					state_d           = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			first_q  <= FIRST_RST;
			limit_q  <= LIMIT_RST;
			num_q    <= '0;
			n_q      <= '0;
			cursor_q <= '0;
			bleft_q  <= BL_W'(BLOCK_BYTES);
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			num_q    <= num_d;
			n_q      <= n_d;
			cursor_q <= cursor_d;
			bleft_q  <= bleft_d;
			ovalid_q <= ovalid_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FIRST: first_q <= cfg_data[FIRST_W-1:0];
					CFG_LIMIT: limit_q <= cfg_data;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		out_q     <= out_d;
		item_q    <= item_d;
		cls_q     <= cls_d;
		size_q    <= size_d;
		rem_q     <= rem_d;
		quo_q     <= quo_d;
		dcnt_q    <= dcnt_d;
		prod_q    <= prod_d;
		ent_q     <= ent_d;
		slot_q    <= slot_d;
		stat_q    <= stat_d;
		addr_q    <= addr_d;
		has_cls_q <= has_cls_d;
	end

`ifndef SYNTHESIS
	a_item_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_item.op != OP_NONE) |=> state_q != S_IDLE)
		else $error("accepted item did not start work");

	a_link_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		lram_we |-> !slot_big)
		else $error("link store written at an unfolded slot");

	a_pop_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP_RD |-> $past(!slot_big))
		else $error("link store read at an unfolded slot");

	a_block_left: assert property (@(posedge clk) disable iff (!arst_n)
		64'(bleft_q) <= 64'(BLOCK_BYTES))
		else $error("block remainder exceeds block size");

	a_num_bound: assert property (@(posedge clk) disable iff (!arst_n)
		64'(num_q) <= 64'(MAX_CLASSES))
		else $error("class count beyond table depth");
`endif

endmodule

[design/ssca_ram.sv]
// Generic single write port RAM with one registered read port.
module ssca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
